[hdl/string_hash_bucket_index_core_assert.svh]
`ifndef STRING_HASH_BUCKET_INDEX_CORE_ASSERT_SVH
`define STRING_HASH_BUCKET_INDEX_CORE_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define SHBI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define SHBI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/shbi_pkg.sv]
package shbi_pkg;

  localparam int SHBI_MAX_BUCKETS = 4096;

  localparam int CHAR_W = 7;
  localparam int IDX_W  = 12;
  localparam int SEL_W  = 2;
  localparam int CNT_W  = 13;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_HASH_SELECT  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BUCKET_COUNT = 1'd1;

  localparam logic [SEL_W-1:0] HS_SDBM = 2'd0;
  localparam logic [SEL_W-1:0] HS_DJB2 = 2'd1;
  localparam logic [SEL_W-1:0] HS_BKDR = 2'd2;

  localparam logic [SEL_W-1:0] HS_RESET    = HS_SDBM;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd7;

  // seed and multiplier widths
  localparam int SEED_W = 13;
  localparam int MUL_W  = 17;
  localparam logic [SEED_W-1:0] SEED_DJB2 = 13'd5381;

  // shift amounts of the multipliers: 65599 = 2^16 + 2^6 - 1, 33 = 2^5 + 1,
  // 131 = 2^7 + 2 + 1
  localparam int SDBM_SH_HI = 16;
  localparam int SDBM_SH_LO = 6;
  localparam int DJB2_SH    = 5;
  localparam int BKDR_SH_HI = 7;
  localparam int BKDR_SH_LO = 1;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

[hdl/shbi_in_if.sv]
interface shbi_in_if
  import shbi_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

[hdl/shbi_out_if.sv]
interface shbi_out_if
  import shbi_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink (input valid, input bucket_index, output ready);
endinterface

[hdl/shbi_mod.sv]
module shbi_mod
  import shbi_pkg::*;
#(
  parameter int DW = 31,
  parameter int NW = 13,
  parameter int RW = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [RW-1:0] rem,
  output mod_stat_t     stat
);

  localparam int DIGITS = 2;
  localparam int STEPS  = (DW + DIGITS - 1) / DIGITS;
  localparam int SW     = STEPS * DIGITS;
  localparam int CNTW   = $clog2(STEPS + 1);

  logic [SW-1:0]   dvd_r, dvd_nxt;
  logic [NW-1:0]   rem_r, rem_nxt;
  logic [NW-1:0]   div_r, div_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NW-1:0]   step_rem;

  // restoring remainder, two dividend bits per cycle
  always_comb begin
    logic [NW:0]   t;
    logic [NW-1:0] r;
    r = rem_r;
    t = '0;
    for (int k = 0; k < DIGITS; k++) begin
      t = {r, dvd_r[SW-1-k]};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[NW-1:0];
    end
    step_rem = r;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(STEPS);
      dvd_nxt  = SW'(dividend);
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = dvd_r << DIGITS;
      rem_nxt = step_rem;
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign rem       = RW'(rem_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/string_hash_bucket_index_core.sv]
// Bucket index of a symbol name, fed one 7-bit character per request with the
// final character flagged; one result per name carries the zero-based bucket.
// hash_select picks sdbm (65599), djb2 (seed 5381, 33) or bkdr (131); a
// selector of three acts as sdbm. bucket_count is clamped to 1..MAX_BUCKETS
// and the running hash is reduced by it after every character. The product of
// a step is W + 18 bits wide, W = max(13, clog2(MAX_BUCKETS)); the shared
// remainder unit retires two bits of it per cycle. A character is taken with
// its request, reduced, and the new hash is then written back.
// in_if.ready is low while a character is in flight. A finished index waits in
// an output register, so the next name can start before it is taken.
module string_hash_bucket_index_core
  import shbi_pkg::*;
#(
  parameter int MAX_BUCKETS = SHBI_MAX_BUCKETS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shbi_in_if.sink               in_if,
  shbi_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(MAX_BUCKETS + 1);
  localparam int MW = (RW > SEED_W) ? RW : SEED_W;
  localparam int PW = MW + MUL_W + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [SEL_W-1:0] sel_r;
  logic [CNT_W-1:0] count_r;
  logic [RW-1:0]    hash_r, hash_nxt;
  logic             name_start_r, name_start_nxt;
  logic             last_r, last_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic             in_accept;
  logic             out_take;
  logic             out_load;
  logic [MW-1:0]    mcand;
  logic [PW-1:0]    m_ext;
  logic [PW-1:0]    product;
  logic [NW-1:0]    eff_count;
  logic [RW-1:0]    mrem;
  mod_stat_t        mstat;

  assign in_if.ready      = (state_r == S_IDLE) && !mstat.busy;
  assign in_accept        = in_if.valid && in_if.ready;
  assign out_take         = out_valid_r && out_if.ready;
  assign out_if.valid     = out_valid_r;
  assign out_if.bucket_index = out_idx_r;

  // seed is taken from the selector at the first character of a name
  always_comb begin
    if (name_start_r) begin
      mcand = (sel_r == HS_DJB2) ? MW'(SEED_DJB2) : '0;
    end else begin
      mcand = MW'(hash_r);
    end
  end

  assign m_ext = PW'(mcand);

  always_comb begin
    unique case (sel_r)
      HS_DJB2: product = (m_ext << DJB2_SH) + m_ext;
      HS_BKDR: product = (m_ext << BKDR_SH_HI) + (m_ext << BKDR_SH_LO) + m_ext;
      default: product = (m_ext << SDBM_SH_HI) + (m_ext << SDBM_SH_LO) - m_ext;
    endcase
    product = product + PW'(in_if.char_code);
  end

  always_comb begin
    if (count_r == '0) begin
      eff_count = NW'(1);
    end else if (32'(count_r) > MAX_BUCKETS) begin
      eff_count = NW'(MAX_BUCKETS);
    end else begin
      eff_count = NW'(count_r);
    end
  end

  shbi_mod #(
    .DW(PW),
    .NW(NW),
    .RW(RW)
  ) u_shbi_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .dividend (product),
    .divisor  (eff_count),
    .rem      (mrem),
    .stat     (mstat)
  );

  always_comb begin
    state_nxt      = state_r;
    hash_nxt       = hash_r;
    name_start_nxt = name_start_r;
    last_nxt       = last_r;
    out_load       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt      = S_RUN;
          last_nxt       = in_if.last_char;
          name_start_nxt = in_if.last_char;
        end
      end
      S_RUN: begin
        if (mstat.done) begin
          hash_nxt = mrem;
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (!out_valid_r || out_if.ready) begin
            out_load  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WAIT;
          end
        end
      end
      // remainder unit holds its result while the output register is full
      S_WAIT: begin
        if (out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_take);
    out_idx_nxt   = out_load ? IDX_W'(mrem) : out_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      name_start_r <= 1'b1;
      out_valid_r  <= 1'b0;
      sel_r        <= HS_RESET;
      count_r      <= COUNT_RESET;
    end else begin
      state_r      <= state_nxt;
      name_start_r <= name_start_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_HASH_SELECT:  sel_r   <= cfg_wdata[SEL_W-1:0];
          CFG_BUCKET_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_r    <= hash_nxt;
    last_r    <= last_nxt;
    out_idx_r <= out_idx_nxt;
  end

endmodule

[hdl/shbi_checker.sv]
`include "string_hash_bucket_index_core_assert.svh"

module shbi_checker
  import shbi_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_last_char,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_bucket_index
);

  logic prev_valid_r;
  logic prev_take_r;
  logic pending_r, pending_nxt;
  logic new_res;

  // a fresh result: valid rises, or a taken one is replaced at once
  assign new_res = out_valid && (!prev_valid_r || prev_take_r);

  always_comb begin
    pending_nxt = pending_r;
    if (new_res) begin
      pending_nxt = 1'b0;
    end
    if (in_valid && in_ready && in_last_char) begin
      pending_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      prev_take_r  <= 1'b0;
      pending_r    <= 1'b0;
    end else begin
      prev_valid_r <= out_valid;
      prev_take_r  <= out_valid && out_ready;
      pending_r    <= pending_nxt;
    end
  end

  `SHBI_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "ready stayed high after a request")
  `SHBI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_bucket_index), "stalled result changed")
  `SHBI_ASSERT_IMP(a_result_needs_last, clk, rst_n, new_res, pending_r, "result without a final character")

endmodule

bind string_hash_bucket_index_core shbi_checker u_shbi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_last_char     (in_if.last_char),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_bucket_index (out_if.bucket_index)
);
